>>> src/occupancy_bitmap_overlap_filter_core_macros.svh
// assertion macros for the occupancy bitmap overlap filter
`ifndef OCCUPANCY_BITMAP_OVERLAP_FILTER_CORE_MACROS_SVH
`define OCCUPANCY_BITMAP_OVERLAP_FILTER_CORE_MACROS_SVH

// check outside reset
`define OBOF_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("obof check failed");

// check that also covers reset cycles
`define OBOF_CHECK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("obof reset check failed");

`endif

>>> src/obof_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obof_pkg
// shared constants of the occupancy bitmap overlap filter
// ---------------------------------------------------------------------------
package obof_pkg;
   localparam int DEF_MAP_BITS   = 16777216;
   localparam int DEF_MAX_BLOCKS = 64;
   localparam int EPOCH_W        = 8;
   localparam int LEN_W          = 25;
   localparam int POS_W          = 24;
   localparam int SIZE_W         = 25;
   localparam int END_W          = 26;
endpackage

>>> src/occupancy_bitmap_overlap_filter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// occupancy_bitmap_overlap_filter_core
// Takes interval records one block per transfer. Every block that lies inside
// the sequence length and the map, up to MAX_BLOCKS per record, is buffered and
// tested against a 64-bit-per-word occupancy map held in one synchronous
// memory; on the record's last block one transfer reports keep or bad_range,
// and a kept record is marked. Each map word carries an epoch tag, so new_chrom
// clears the map by bumping the epoch. A block is checked, then each map word
// it covers is read and tested, stopping at the first overlap; a record's last
// block then posts its result, waiting while a previous result is still
// stalled. A kept record then rereads each buffered block and marks each map
// word with one read-modify-write of the map port. After reset, and on every
// new_chrom that wraps the epoch (once every 2**EPOCH_W sequences), a clearing
// pass walks the map while no block is accepted.
// ---------------------------------------------------------------------------
module occupancy_bitmap_overlap_filter_core
   import obof_pkg::*;
#(
   parameter int MAP_BITS   = DEF_MAP_BITS,
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_new_chrom,
   input  logic [LEN_W-1:0]  req_chrom_length,
   input  logic [POS_W-1:0]  req_record_start,
   input  logic [POS_W-1:0]  req_block_offset,
   input  logic [SIZE_W-1:0] req_block_size,
   input  logic              req_last_block,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_keep,
   output logic              rsp_bad_range
);

   localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW        = $clog2(MAX_BLOCKS + 1);
   localparam int PIW       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int S_W       = POS_W + 1;
   localparam int PEND_W    = S_W + SIZE_W;
   localparam int MEM_W     = EPOCH_W + 64;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_EVAL, ST_TRD, ST_TCMP, ST_DECIDE,
      ST_PRD, ST_PSET, ST_MRD, ST_MWR, ST_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [S_W-1:0]     s_ff, s_in;
   logic [SIZE_W-1:0]  sz_ff, sz_in;
   logic               last_ff, last_in;
   logic [AW-1:0]      w_ff, w_in;
   logic [AW-1:0]      wlast_ff, wlast_in;
   logic [5:0]         lo_ff, lo_in;
   logic [5:0]         hi_ff, hi_in;
   logic               first_ff, first_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      i_ff, i_in;
   logic               err_ff, err_in;
   logic               ovl_ff, ovl_in;
   logic               item_ff, item_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_keep_ff, rsp_keep_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [MEM_W-1:0]   map_mem [MAP_WORDS];
   logic [MEM_W-1:0]   rdata_ff;
   logic               map_we;
   logic [MEM_W-1:0]   map_wd;
   logic [PEND_W-1:0]  pend_mem [MAX_BLOCKS];
   logic [PEND_W-1:0]  pr_ff;
   logic               pend_we;

   logic [S_W-1:0]     rg_s;
   logic [SIZE_W-1:0]  rg_sz;
   logic [END_W-1:0]   rg_e, rg_em1;
   logic [63:0]        word_data, mask;
   logic [5:0]         lo_eff, hi_eff;
   logic               accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_keep      = rsp_keep_ff;
   assign rsp_bad_range = rsp_bad_ff;

   // range setup shared by test and mark walks
   always_comb begin
      if (state_ff == ST_PSET) begin
         rg_s  = pr_ff[PEND_W-1:SIZE_W];
         rg_sz = pr_ff[SIZE_W-1:0];
      end else begin
         rg_s  = s_ff;
         rg_sz = sz_ff;
      end
      rg_e   = END_W'(rg_s) + END_W'(rg_sz);
      rg_em1 = rg_e - END_W'(1);
   end

   assign word_data = (rdata_ff[MEM_W-1:64] == epoch_ff) ? rdata_ff[63:0] : 64'd0;
   assign lo_eff    = first_ff ? lo_ff : 6'd0;
   assign hi_eff    = (w_ff == wlast_ff) ? hi_ff : 6'd63;
   assign mask      = ({64{1'b1}} >> (6'd63 - hi_eff)) & ({64{1'b1}} << lo_eff);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      s_in         = s_ff;
      sz_in        = sz_ff;
      last_in      = last_ff;
      w_in         = w_ff;
      wlast_in     = wlast_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      err_in       = err_ff;
      ovl_in       = ovl_ff;
      item_in      = item_ff;
      epoch_in     = epoch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_keep_in  = rsp_keep_ff;
      rsp_bad_in   = rsp_bad_ff;
      map_we       = 1'b0;
      map_wd       = {epoch_ff, word_data | mask};
      pend_we      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in    = S_W'(req_record_start) + S_W'(req_block_offset);
               sz_in   = req_block_size;
               last_in = req_last_block;
               item_in = 1'b1;
               state_in = ST_EVAL;
               if (req_new_chrom) begin
                  len_in = req_chrom_length;
                  cnt_in = '0;
                  ovl_in = 1'b0;
                  err_in = 1'b0;
                  if (epoch_ff == EPOCH_MAX) begin
                     epoch_in = '0;
                     w_in     = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
               end
            end
         end
         ST_CLEAR: begin
            map_we = 1'b1;
            map_wd = '0;
            w_in   = w_ff + AW'(1);
            if (w_ff == AW'(MAP_WORDS - 1)) begin
               state_in = item_ff ? ST_EVAL : ST_IDLE;
            end
         end
         ST_EVAL: begin
            state_in = ST_DECIDE;
            if ((32'(rg_e) > 32'(len_ff)) || (32'(rg_e) > 32'(MAP_BITS))) begin
               err_in = 1'b1;
            end else if (cnt_ff >= CW'(MAX_BLOCKS)) begin
               err_in = 1'b1;
            end else begin
               pend_we  = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               w_in     = AW'(rg_s >> 6);
               wlast_in = AW'(rg_em1 >> 6);
               lo_in    = rg_s[5:0];
               hi_in    = rg_em1[5:0];
               first_in = 1'b1;
               if (END_W'(rg_s) < rg_e) begin
                  state_in = ST_TRD;
               end
            end
         end
         ST_TRD: begin
            state_in = ST_TCMP;
         end
         ST_TCMP: begin
            if ((word_data & mask) != 64'd0) begin
               ovl_in   = 1'b1;
               state_in = ST_DECIDE;
            end else if (w_ff == wlast_ff) begin
               state_in = ST_DECIDE;
            end else begin
               w_in     = w_ff + AW'(1);
               first_in = 1'b0;
               state_in = ST_TRD;
            end
         end
         ST_DECIDE: begin
            if (!last_ff) begin
               item_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (err_ff || ovl_ff) begin
               state_in = ST_FIN;
            end else begin
               i_in     = '0;
               state_in = ST_PRD;
            end
         end
         ST_PRD: begin
            state_in = ST_PSET;
         end
         ST_PSET: begin
            w_in     = AW'(rg_s >> 6);
            wlast_in = AW'(rg_em1 >> 6);
            lo_in    = rg_s[5:0];
            hi_in    = rg_em1[5:0];
            first_in = 1'b1;
            i_in     = i_ff + CW'(1);
            if (END_W'(rg_s) < rg_e) begin
               state_in = ST_MRD;
            end else if (i_ff + CW'(1) == cnt_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_PRD;
            end
         end
         ST_MRD: begin
            state_in = ST_MWR;
         end
         ST_MWR: begin
            map_we = 1'b1;
            if (w_ff != wlast_ff) begin
               w_in     = w_ff + AW'(1);
               first_in = 1'b0;
               state_in = ST_MRD;
            end else if (i_ff == cnt_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_PRD;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = !err_ff && !ovl_ff;
               rsp_bad_in   = err_ff;
               cnt_in       = '0;
               ovl_in       = 1'b0;
               err_in       = 1'b0;
               item_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= '0;
         w_ff         <= '0;
         cnt_ff       <= '0;
         i_ff         <= '0;
         err_ff       <= 1'b0;
         ovl_ff       <= 1'b0;
         item_ff      <= 1'b0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         w_ff         <= w_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         err_ff       <= err_in;
         ovl_ff       <= ovl_in;
         item_ff      <= item_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff        <= s_in;
      sz_ff       <= sz_in;
      last_ff     <= last_in;
      wlast_ff    <= wlast_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      first_ff    <= first_in;
      rsp_keep_ff <= rsp_keep_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // occupancy map, tagged with the sequence epoch
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[w_ff] <= map_wd;
      end
      rdata_ff <= map_mem[w_ff];
   end

   // buffered block ranges
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[cnt_ff[PIW-1:0]] <= {s_ff, sz_ff};
      end
      pr_ff <= pend_mem[i_ff[PIW-1:0]];
   end

endmodule

>>> src/obof_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obof_checker
// port-level checks of the occupancy bitmap overlap filter
// ---------------------------------------------------------------------------
`include "occupancy_bitmap_overlap_filter_core_macros.svh"

module obof_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_keep,
   input logic rsp_bad_range
);

   `OBOF_CHECK(rsp_hold_chk, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_keep) && $stable(rsp_bad_range))
   `OBOF_CHECK(keep_bad_chk, rsp_valid |-> !(rsp_keep && rsp_bad_range))
   `OBOF_CHECK_RST(rst_rsp_chk, reset |=> !rsp_valid)
   `OBOF_CHECK_RST(rst_clear_chk, reset |=> req_stall)

endmodule

bind occupancy_bitmap_overlap_filter_core obof_checker u_obof_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_keep      (rsp_keep),
   .rsp_bad_range (rsp_bad_range)
);

>>> bench/occupancy_bitmap_overlap_filter_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// occupancy_bitmap_overlap_filter_core_tb
// Sends interval blocks to the overlap filter with bursty valid and a
// patterned result stall. A scoreboard keeps a sparse copy of the occupancy
// map, predicts keep and bad_range for each record and checks every result.
// ---------------------------------------------------------------------------
module occupancy_bitmap_overlap_filter_core_tb;
   import obof_pkg::*;

   localparam longint MAP_SZ  = DEF_MAP_BITS;
   localparam int     BLK_MAX = DEF_MAX_BLOCKS;
   localparam longint FULL    = 64'd16777216;

   class record_scoreboard;
      bit [63:0]   occ[longint];
      longint      pend_s[BLK_MAX];
      longint      pend_e[BLK_MAX];
      int          pend_n;
      bit          hit;
      bit          bad;
      longint      seq_len;
      bit [1:0]    verdicts[$];
      int          errors;

      function void clear_record();
         pend_n = 0;
         hit    = 0;
         bad    = 0;
      endfunction

      // test or mark bits [s, e)
      function bit walk(longint s, longint e, bit mark);
         longint    w;
         longint    lo;
         longint    hi;
         bit [63:0] m;
         if (s >= e) return 0;
         for (w = s >> 6; w <= (e - 1) >> 6; w++) begin
            lo = (w == s >> 6) ? (s & 63) : 0;
            hi = (w == (e - 1) >> 6) ? (((e - 1) & 63) + 1) : 64;
            m  = (hi >= 64) ? '1 : ((64'd1 << hi) - 1);
            m &= ~((64'd1 << lo) - 1);
            if (mark) begin
               if (occ.exists(w)) occ[w] |= m;
               else occ[w] = m;
            end else if (occ.exists(w) && (occ[w] & m) != 0) begin
               return 1;
            end
         end
         return 0;
      endfunction

      function void note_block(bit nc, longint len, longint rs, longint off,
                               longint sz, bit last);
         longint s;
         longint e;
         int     i;
         if (nc) begin
            occ.delete();
            seq_len = len;
            clear_record();
         end
         s = rs + off;
         e = s + sz;
         if (e > seq_len || e > MAP_SZ) begin
            bad = 1;
         end else if (pend_n >= BLK_MAX) begin
            bad = 1;
         end else begin
            pend_s[pend_n] = s;
            pend_e[pend_n] = e;
            pend_n++;
            if (walk(s, e, 0)) hit = 1;
         end
         if (!last) return;
         if (bad) begin
            verdicts.push_back(2'b01);
         end else if (hit) begin
            verdicts.push_back(2'b00);
         end else begin
            for (i = 0; i < pend_n; i++) void'(walk(pend_s[i], pend_e[i], 1));
            verdicts.push_back(2'b10);
         end
         clear_record();
      endfunction

      function void check_result(bit keep, bit bad_range);
         bit [1:0] exp_v;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected result keep=%0b bad_range=%0b",
                     $time, keep, bad_range);
            errors++;
            return;
         end
         exp_v = verdicts.pop_front();
         if (keep != exp_v[1]) begin
            $display("%0t: keep expected %0b actual %0b", $time, exp_v[1], keep);
            errors++;
         end
         if (bad_range != exp_v[0]) begin
            $display("%0t: bad_range expected %0b actual %0b",
                     $time, exp_v[0], bad_range);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_new_chrom;
   logic [LEN_W-1:0]  req_chrom_length;
   logic [POS_W-1:0]  req_record_start;
   logic [POS_W-1:0]  req_block_offset;
   logic [SIZE_W-1:0] req_block_size;
   logic              req_last_block;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_keep;
   logic              rsp_bad_range;

   record_scoreboard sb;
   int               burst_left;
   int               stall_mode;
   int               stall_cnt;
   longint           seq_base;
   longint           seq_span;

   occupancy_bitmap_overlap_filter_core dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("occupancy_bitmap_overlap_filter_core test failed");
      $finish;
   end

   // result side: stall pattern picks among four modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 0;
         stall_cnt  <= 0;
         stall_mode <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_keep, rsp_bad_range);
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt % 48 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (stall_cnt % 3 != 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   task automatic send_block(bit nc, longint len, longint rs, longint off,
                             longint sz, bit last);
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid        <= 1;
      req_new_chrom    <= nc;
      req_chrom_length <= len[LEN_W-1:0];
      req_record_start <= rs[POS_W-1:0];
      req_block_offset <= off[POS_W-1:0];
      req_block_size   <= sz[SIZE_W-1:0];
      req_last_block   <= last;
      do @(posedge clock); while (req_stall);
      sb.note_block(nc, len & 64'h1FFFFFF, rs & 64'hFFFFFF, off & 64'hFFFFFF,
                    sz & 64'h1FFFFFF, last);
   endtask

   task automatic new_sequence();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) seq_span = FULL;
      else if (pick == 1) seq_span = $urandom_range(3000, 20000);
      else seq_span = {$urandom_range(0, 1), $urandom()} & 64'h1FFFFFF;
      if (seq_span < 3000) seq_span = 3000;
      if (seq_span > FULL) seq_span = FULL;
      seq_base = (seq_span > 3000) ? ({$urandom()} % (seq_span - 2999)) : 0;
   endtask

   task automatic random_record();
      int     nblk;
      int     i;
      bit     nc;
      longint rs;
      longint sz;
      nc = ($urandom_range(0, 9) == 0);
      if (nc) new_sequence();
      nblk = $urandom_range(1, 5);
      rs   = seq_base + $urandom_range(0, 2500);
      for (i = 0; i < nblk; i++) begin
         sz = $urandom_range(0, 60);
         if ($urandom_range(0, 30) == 0) sz = $urandom_range(0, 600);
         send_block(nc && i == 0, seq_span, rs, $urandom_range(0, 200), sz,
                    i == nblk - 1);
      end
   endtask

   task automatic noise_block();
      send_block($urandom_range(0, 15) == 0, {$urandom_range(0, 1), $urandom()},
                 $urandom(), $urandom(), {$urandom_range(0, 1), $urandom()},
                 $urandom_range(0, 1));
   endtask

   initial begin
      int i;
      sb               = new();
      sb.seq_len       = 0;
      sb.errors        = 0;
      sb.clear_record();
      burst_left       = 0;
      reset            = 1;
      req_valid        = 0;
      req_new_chrom    = 0;
      req_chrom_length = 0;
      req_record_start = 0;
      req_block_offset = 0;
      req_block_size   = 0;
      req_last_block   = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero length before any sequence
      send_block(0, 0, 0, 0, 0, 1);
      send_block(0, 0, 0, 0, 1, 1);
      // top of the map, then the same position again
      send_block(1, FULL, 24'hFFFFFF, 0, 1, 1);
      send_block(0, 0, 24'hFFFFFF, 0, 1, 1);
      send_block(0, 0, 24'hFFFFFF, 24'hFFFFFF, FULL, 1);
      // self-overlapping record with an empty block, then a clash
      send_block(1, 1000, 100, 0, 10, 0);
      send_block(0, 0, 100, 5, 10, 0);
      send_block(0, 0, 100, 50, 0, 1);
      send_block(0, 0, 110, 4, 3, 1);
      // block past the end inside an otherwise good record
      send_block(0, 0, 500, 0, 4, 0);
      send_block(0, 0, 990, 0, 20, 0);
      send_block(0, 0, 600, 0, 4, 1);
      send_block(0, 0, 2000, 0, 0, 1);
      // new sequence in mid-record
      send_block(0, 0, 0, 0, 5, 0);
      send_block(1, 1000, 0, 0, 5, 1);
      send_block(0, 0, 0, 2, 1, 1);
      // wide range then a one-bit hit at its last position
      send_block(1, FULL, 24'h800000, 0, 65536, 1);
      send_block(0, 0, 24'h80FFFF, 0, 1, 1);
      send_block(0, 0, 24'h810000, 0, 1, 1);
      // too many blocks, then exactly the limit
      for (i = 0; i <= BLK_MAX; i++) send_block(0, 0, 24'h400000, i, 1, i == BLK_MAX);
      for (i = 0; i < BLK_MAX; i++) send_block(0, 0, 24'h400000, i, 1, i == BLK_MAX - 1);

      new_sequence();
      send_block(1, seq_span, seq_base, 0, 1, 1);
      i = 0;
      while (i < 300) begin
         if ($urandom_range(0, 9) == 0) begin
            noise_block();
            i++;
         end else begin
            random_record();
            i += 3;
         end
      end
      req_valid <= 0;

      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("occupancy_bitmap_overlap_filter_core test passed");
      else
         $display("occupancy_bitmap_overlap_filter_core test failed");
      $finish;
   end
endmodule
